// ===== rtl/spq_pkg.sv =====
// Shared types and codes for the stable priority queue.
// Depends on nothing; used by the cell and the top level.
`default_nettype none

package spq_pkg;

   // Action codes on the request channel.
   localparam logic [1:0] ACT_ENQUEUE = 2'd0;
   localparam logic [1:0] ACT_DEQUEUE = 2'd1;
   localparam logic [1:0] ACT_CLEAR   = 2'd2;

   // Status codes on the response channel.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // One stored entry of the queue.
   typedef struct packed {
      logic               valid;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } entry_type;

   // Command broadcast to every cell at once.
   typedef struct packed {
      logic               enq;
      logic               deq;
      logic               clr;
      logic signed [31:0] data;
      logic signed [31:0] prio;
   } cmd_type;

endpackage

`default_nettype wire

// ===== rtl/spq_cell.sv =====
// One slot of the sorted queue chain: holds an entry and shifts with its neighbors.
// Depends on spq_pkg for the entry and command types.
`default_nettype none

module spq_cell
   import spq_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   input  wire entry_type left_entry,
   input  wire logic      left_keep,
   input  wire entry_type right_entry,
   output entry_type      entry_out,
   output entry_type      entry_next,
   output logic           keep
);

   entry_type entry_ff;
   entry_type entry_in;

   // An entry stays in place on insert when it is served before the new one.
   assign keep = entry_ff.valid && (entry_ff.prio >= cmd.prio);

   // Next entry: clear it, keep it, take the new word, take the left entry, or take the right one.
   always_comb begin
      entry_in = entry_ff;
      if (cmd.clr) begin
         entry_in.valid = 1'b0;
      end else if (cmd.deq) begin
         entry_in = right_entry;
      end else if (cmd.enq && !keep) begin
         if (left_keep) begin
            entry_in.valid = 1'b1;
            entry_in.data  = cmd.data;
            entry_in.prio  = cmd.prio;
         end else begin
            entry_in = left_entry;
         end
      end
   end

   // Only the valid bit needs a reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.data <= entry_in.data;
      entry_ff.prio <= entry_in.prio;
   end

   assign entry_out  = entry_ff;
   assign entry_next = entry_in;

endmodule

`default_nettype wire

// ===== rtl/stable_priority_queue.sv =====
// Stable priority queue: a chain of DEPTH cells kept in descending priority order.
// The response is registered and appears in the cycle after the request transaction.
// Throughput: one transaction per cycle while the response is not stalled; every cell compares and shifts in parallel.
// A new request is taken while the previous response is taken in the same cycle.
// Reset empties the queue and drops any pending response.
// Depends on spq_pkg and spq_cell.
`default_nettype none

module stable_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic        [1:0]  req_action,
   input  wire logic signed [31:0] req_data_value,
   input  wire logic signed [31:0] req_priority_req,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic             [1:0]  rsp_status,
   output logic signed      [31:0] rsp_taken_data,
   output logic signed      [31:0] rsp_head_data,
   output logic signed      [31:0] rsp_head_priority,
   output logic             [4:0]  rsp_entry_count,
   output logic                    rsp_is_empty
);

   localparam int CW = $clog2(DEPTH + 1);

   entry_type cur   [DEPTH];
   entry_type nxt   [DEPTH];
   logic      keeps [DEPTH];

   logic          accept;
   logic          full;
   logic          empty;
   cmd_type       cmd;
   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic [CW+4:0] cnt_wide;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic        [1:0]  status_ff;
   logic        [1:0]  status_in;
   logic signed [31:0] taken_ff;
   logic signed [31:0] taken_in;
   logic signed [31:0] head_data_ff;
   logic signed [31:0] head_prio_ff;
   logic        [4:0]  count_ff;
   logic               empty_ff;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = cur[DEPTH-1].valid;
   assign empty     = !cur[0].valid;

   // Decode the accepted transaction into a command for all cells.
   always_comb begin
      cmd.enq  = accept && (req_action == ACT_ENQUEUE) && !full;
      cmd.deq  = accept && (req_action == ACT_DEQUEUE) && !empty;
      cmd.clr  = accept && (req_action == ACT_CLEAR);
      cmd.data = req_data_value;
      cmd.prio = req_priority_req;
   end

   // The chain of cells; the front cell always sees an inserting left neighbor.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      entry_type left_e;
      entry_type right_e;
      logic      left_k;

      if (i == 0) begin : g_first
         assign left_e = '0;
         assign left_k = 1'b1;
      end else begin : g_mid
         assign left_e = cur[i-1];
         assign left_k = keeps[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_e = '0;
      end else begin : g_inner
         assign right_e = cur[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (left_e),
         .left_keep   (left_k),
         .right_entry (right_e),
         .entry_out   (cur[i]),
         .entry_next  (nxt[i]),
         .keep        (keeps[i])
      );
   end

   // Entry count follows the accepted commands.
   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clr) begin
         cnt_in = '0;
      end else if (cmd.enq) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.deq) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   assign cnt_wide = (CW + 5)'(cnt_in);

   // Status and removed word for the response.
   always_comb begin
      status_in = STATUS_OK;
      taken_in  = '0;
      if (req_action == ACT_ENQUEUE && full) begin
         status_in = STATUS_FULL;
      end else if (req_action == ACT_DEQUEUE) begin
         if (empty) begin
            status_in = STATUS_EMPTY;
         end else begin
            taken_in = cur[0].data;
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload is loaded on each accepted transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff    <= status_in;
         taken_ff     <= taken_in;
         head_data_ff <= nxt[0].valid ? nxt[0].data : 32'sd0;
         head_prio_ff <= nxt[0].valid ? nxt[0].prio : 32'sd0;
         count_ff     <= cnt_wide[4:0];
         empty_ff     <= !nxt[0].valid;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_taken_data    = taken_ff;
   assign rsp_head_data     = head_data_ff;
   assign rsp_head_priority = head_prio_ff;
   assign rsp_entry_count   = count_ff;
   assign rsp_is_empty      = empty_ff;

endmodule

`default_nettype wire

// ===== verif/stable_priority_queue_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_queue: enqueue, dequeue and clear transactions
// with random idling on both channels, each response checked against a local queue model.
// Depends on spq_pkg and the stable_priority_queue RTL.

module stable_priority_queue_test
   import spq_pkg::*;
();

   localparam int DEPTH = 16;
   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 10;
   localparam int SETTLE_CYCLES = 4;
   localparam int TIMEOUT_CYCLES = 100000;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // Everything one response carries.
   typedef struct {
      logic [1:0]         status;
      logic signed [31:0] taken_data;
      logic signed [31:0] head_data;
      logic signed [31:0] head_priority;
      logic [4:0]         entry_count;
      logic               is_empty;
   } outcome_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic        [1:0]  req_action;
   logic signed [31:0] req_data_value;
   logic signed [31:0] req_priority_req;
   logic               rsp_valid;
   logic               rsp_stall;
   logic        [1:0]  rsp_status;
   logic signed [31:0] rsp_taken_data;
   logic signed [31:0] rsp_head_data;
   logic signed [31:0] rsp_head_priority;
   logic        [4:0]  rsp_entry_count;
   logic               rsp_is_empty;

   // Entries in service order, front first, and responses still owed by the block.
   entry_type   held_entries[$];
   outcome_type owed_outcomes[$];
   int          error_count = 0;
   bit          idle_on = 1'b1;
   bit          filling = 1'b1;

   stable_priority_queue #(.DEPTH(DEPTH)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_data_value    (req_data_value),
      .req_priority_req  (req_priority_req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_taken_data    (rsp_taken_data),
      .rsp_head_data     (rsp_head_data),
      .rsp_head_priority (rsp_head_priority),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("status: fail");
      $finish;
   end

   // Applies one action to the local queue and returns the response it should cause.
   function automatic outcome_type apply_action(input logic [1:0] action,
                                                input logic signed [31:0] data_value,
                                                input logic signed [31:0] priority_req);
      outcome_type result;
      entry_type   slot;
      int          pos;
      result.status = STATUS_OK;
      result.taken_data = '0;
      case (action)
         ACT_ENQUEUE: begin
            if (held_entries.size() >= DEPTH) begin
               result.status = STATUS_FULL;
            end else begin
               // New entry goes behind every entry of greater or equal priority.
               pos = 0;
               while (pos < held_entries.size() &&
                      $signed(held_entries[pos].prio) >= $signed(priority_req))
                  pos++;
               slot.valid = 1'b1;
               slot.data = data_value;
               slot.prio = priority_req;
               held_entries.insert(pos, slot);
            end
         end
         ACT_DEQUEUE: begin
            if (held_entries.size() == 0) begin
               result.status = STATUS_EMPTY;
            end else begin
               slot = held_entries.pop_front();
               result.taken_data = slot.data;
            end
         end
         ACT_CLEAR: begin
            held_entries.delete();
         end
         default: begin
         end
      endcase
      if (held_entries.size() != 0) begin
         result.head_data = held_entries[0].data;
         result.head_priority = held_entries[0].prio;
      end else begin
         result.head_data = '0;
         result.head_priority = '0;
      end
      result.entry_count = 5'(held_entries.size());
      result.is_empty = (held_entries.size() == 0);
      return result;
   endfunction

   // Priorities cluster on a few values so that ties are common, with the extremes mixed in.
   function automatic logic signed [31:0] pick_priority();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2, 3, 4, 5: return 32'($urandom_range(0, 6)) - 32'd3;
         default: return $urandom;
      endcase
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected 'h%08h, actual 'h%08h", name, want, got);
         error_count++;
      end
   endtask

   // Sends one transaction, idling first at random, and records its expected response.
   task automatic send_action(input logic [1:0] action,
                              input logic signed [31:0] data_value,
                              input logic signed [31:0] priority_req);
      @(negedge clock);
      while (idle_on && $urandom_range(0, 99) < 30) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_action <= action;
      req_data_value <= data_value;
      req_priority_req <= priority_req;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owed_outcomes.push_back(apply_action(action, data_value, priority_req));
   endtask

   // Stops sending and waits until every owed response has come back.
   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_outcomes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random action, biased to fill the queue up to full and then drain it to empty.
   task automatic send_random_action();
      int         pick;
      logic [1:0] action;
      if (held_entries.size() >= DEPTH)
         filling = 1'b0;
      else if (held_entries.size() == 0)
         filling = 1'b1;
      else if ($urandom_range(0, 99) < 3)
         filling = ~filling;
      pick = $urandom_range(0, 99);
      if (pick < 3)
         action = ACT_CLEAR;
      else if (pick < 5)
         action = ACT_UNUSED;
      else if (pick < 75)
         action = filling ? ACT_ENQUEUE : ACT_DEQUEUE;
      else
         action = filling ? ACT_DEQUEUE : ACT_ENQUEUE;
      send_action(action, $urandom, pick_priority());
   endtask

   // Dequeue, clear and the unused code on an empty queue.
   task automatic test_empty_queue();
      send_action(ACT_DEQUEUE, $urandom, $urandom);
      send_action(ACT_CLEAR, $urandom, $urandom);
      send_action(ACT_UNUSED, $urandom, $urandom);
   endtask

   // Extreme data and priority values, served back in priority order.
   task automatic test_extremes();
      send_action(ACT_ENQUEUE, 32'h8000_0000, 32'h8000_0000);
      send_action(ACT_ENQUEUE, 32'h7fff_ffff, 32'h7fff_ffff);
      send_action(ACT_ENQUEUE, 32'h0000_0000, 32'h0000_0000);
      send_action(ACT_ENQUEUE, 32'hffff_ffff, 32'hffff_ffff);
      repeat (4) send_action(ACT_DEQUEUE, $urandom, $urandom);
   endtask

   // Equal priorities must leave in arrival order, behind any higher priority.
   task automatic test_stable_ties();
      send_action(ACT_ENQUEUE, 32'd1, 32'd5);
      send_action(ACT_ENQUEUE, 32'd2, 32'd5);
      send_action(ACT_ENQUEUE, 32'd3, 32'd5);
      send_action(ACT_ENQUEUE, 32'd4, 32'd9);
      send_action(ACT_ENQUEUE, 32'd5, 32'd5);
      repeat (5) send_action(ACT_DEQUEUE, $urandom, $urandom);
   endtask

   // Clear of a loaded queue, and the unused code leaving a loaded queue alone.
   task automatic test_clear();
      send_action(ACT_ENQUEUE, $urandom, pick_priority());
      send_action(ACT_UNUSED, $urandom, $urandom);
      send_action(ACT_CLEAR, $urandom, $urandom);
      send_action(ACT_DEQUEUE, $urandom, $urandom);
   endtask

   // Fill past capacity so one enqueue is dropped, then drain past empty.
   task automatic test_full_queue();
      repeat (DEPTH + 1) send_action(ACT_ENQUEUE, $urandom, pick_priority());
      repeat (DEPTH + 1) send_action(ACT_DEQUEUE, $urandom, $urandom);
   endtask

   // Random fill and drain cycles with a pause halfway for every response to return.
   task automatic test_random_traffic(input int count);
      for (int i = 0; i < count; i++) begin
         if (i == count / 2)
            wait_for_drain();
         send_random_action();
      end
   endtask

   // Random traffic with neither side idling.
   task automatic test_back_to_back(input int count);
      idle_on = 1'b0;
      repeat (count) send_random_action();
      idle_on = 1'b1;
   endtask

   // The receiver stalls at random while idling is on.
   always @(negedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(0, 99) < 30);
   end

   // Every accepted response is compared with the oldest owed one.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (owed_outcomes.size() == 0) begin
            $error("response transaction with no request outstanding");
            error_count++;
         end else begin
            want = owed_outcomes.pop_front();
            check_field("status", 32'(want.status), 32'(rsp_status));
            check_field("taken_data", want.taken_data, rsp_taken_data);
            check_field("head_data", want.head_data, rsp_head_data);
            check_field("head_priority", want.head_priority, rsp_head_priority);
            check_field("entry_count", 32'(want.entry_count), 32'(rsp_entry_count));
            check_field("is_empty", 32'(want.is_empty), 32'(rsp_is_empty));
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = ACT_ENQUEUE;
      req_data_value = '0;
      req_priority_req = '0;
      rsp_stall = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_queue();
      test_extremes();
      test_stable_ties();
      test_clear();
      test_full_queue();
      test_random_traffic(300);
      test_back_to_back(150);
      test_random_traffic(150);
      wait_for_drain();

      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
verif/stable_priority_queue_test.sv
